/* rtl/icad_pkg.sv */
// Shared types, widths and arithmetic helpers for the interval capacity admission block.
package icad_pkg;

  localparam int LOAD_W  = 16;
  localparam int TOTAL_W = 32;

  typedef logic [LOAD_W-1:0]  load_t;
  typedef logic [TOTAL_W-1:0] total_t;

  // One finished transaction as it leaves the sequencer
  typedef struct packed {
    load_t  granted;
    total_t running_total;
    logic   job_done;
  } result_t;

  // Add a grant to a segment load, pinned at the top of the load range
  function automatic load_t sat_load_add(input load_t load, input load_t grant);
    logic [LOAD_W:0] sum;
    sum = {1'b0, load} + {1'b0, grant};
    return sum[LOAD_W] ? {LOAD_W{1'b1}} : sum[LOAD_W-1:0];
  endfunction

  // Smaller of the request and the headroom left above the peak load
  function automatic load_t grant_calc(input load_t peak, input load_t cap,
                                       input load_t want);
    load_t room;
    room = (peak >= cap) ? '0 : load_t'(cap - peak);
    return (want < room) ? want : room;
  endfunction

  // Add a grant to the running total, pinned at the top of the total range
  function automatic total_t sat_total_add(input total_t total, input load_t grant);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, total} + {{(TOTAL_W-LOAD_W+1){1'b0}}, grant};
    return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  endfunction

endpackage

/* rtl/interval_capacity_admission_top.sv */
// Top level of the interval capacity admission block: capacity register, sequencer and store.
//
// A request is taken when start is high and busy is low. A reservation holds
// busy high while one pass reads its range (after clamping the end to the
// path) through the single read port for the peak load and a second pass
// reads each entry again and writes it back with the grant added, one segment
// per cycle; each pass ends by draining the read pipeline. The result appears
// in the same cycle that busy falls, and the next request can be taken in
// that same cycle. A clear command, and the pass that follows reset, sweep
// all NUM_SEGMENTS entries one per cycle with busy high; a clear command
// answers in the cycle after its sweep. Each result appears on granted,
// running_total and job_done while done is high for a single cycle; the
// receiver cannot stall it and must take it then. Write cfg_wdata with cfg_we
// only while busy is low.
module interval_capacity_admission_top #(
  parameter int NUM_SEGMENTS = 2048
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    command,
  input  logic [10:0]             start_segment,
  input  logic [11:0]             end_segment,
  input  icad_pkg::load_t         requested,
  input  logic                    last_request,
  input  logic                    cfg_we,
  input  icad_pkg::load_t         cfg_wdata,
  output logic                    done,
  output icad_pkg::load_t         granted,
  output icad_pkg::total_t        running_total,
  output logic                    job_done
);
  import icad_pkg::*;

  localparam int SEG_W = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int CMP_W = (SEG_W + 1 > 12) ? SEG_W + 1 : 12;

  load_t            capacity;
  logic             mem_wr_en;
  logic [SEG_W-1:0] mem_wr_addr;
  load_t            mem_wr_data;
  logic             mem_rd_en;
  logic [SEG_W-1:0] mem_rd_addr;
  load_t            mem_rd_data;
  result_t          result;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= {LOAD_W{1'b1}};
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  icad_ctrl #(
    .NUM_SEGMENTS (NUM_SEGMENTS),
    .SEG_W        (SEG_W),
    .CMP_W        (CMP_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .start_segment (start_segment),
    .end_segment   (end_segment),
    .requested     (requested),
    .last_request  (last_request),
    .capacity      (capacity),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .done          (done),
    .result        (result)
  );

  icad_seg_mem #(
    .DEPTH  (NUM_SEGMENTS),
    .ADDR_W (SEG_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign granted       = result.granted;
  assign running_total = result.running_total;
  assign job_done      = result.job_done;

  // An accepted transaction always occupies the sequencer next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // A nonzero grant leaves a nonzero total
  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && (granted != '0)) |-> (running_total != '0))
    else $error("nonzero grant with zero running total");

endmodule

/* rtl/icad_seg_mem.sv */
// Segment load store: one write port, one registered read port.
module icad_seg_mem #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  icad_pkg::load_t           wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output icad_pkg::load_t           rd_data
);
  import icad_pkg::*;

  load_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/icad_ctrl.sv */
// Sequencer: clear sweep, peak scan, read-modify-write pass and result register.
module icad_ctrl #(
  parameter int NUM_SEGMENTS = 2048,
  parameter int SEG_W        = 11,
  parameter int CMP_W        = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  command,
  input  logic [10:0]           start_segment,
  input  logic [11:0]           end_segment,
  input  icad_pkg::load_t       requested,
  input  logic                  last_request,
  input  icad_pkg::load_t       capacity,
  output logic                  mem_wr_en,
  output logic [SEG_W-1:0]      mem_wr_addr,
  output icad_pkg::load_t       mem_wr_data,
  output logic                  mem_rd_en,
  output logic [SEG_W-1:0]      mem_rd_addr,
  input  icad_pkg::load_t       mem_rd_data,
  output logic                  done,
  output icad_pkg::result_t     result
);
  import icad_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_GRANT = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [CMP_W-1:0] NUM_C  = CMP_W'(NUM_SEGMENTS);
  localparam logic [CMP_W-1:0] LAST_C = CMP_W'(NUM_SEGMENTS - 1);

  logic [2:0]       state;
  logic [CMP_W-1:0] ptr;
  logic [CMP_W-1:0] start_q;
  logic [CMP_W-1:0] end_q;
  logic             rd_valid;
  logic [SEG_W-1:0] rd_addr_q;
  load_t            peak;
  load_t            grant;
  load_t            req_q;
  logic             last_q;
  logic             clr_reply;
  total_t           total;
  total_t           total_next;
  logic [CMP_W-1:0] start_ext;
  logic [CMP_W-1:0] end_ext;
  logic [CMP_W-1:0] end_clamp;

  assign busy = (state != ST_IDLE);

  // Clamp the range end to the path length
  assign start_ext = CMP_W'(start_segment);
  assign end_ext   = CMP_W'(end_segment);
  assign end_clamp = (end_ext > NUM_C) ? NUM_C : end_ext;

  assign total_next = sat_total_add(total, grant);

  // Memory requests: reads run one entry ahead of write-back, so no entry is
  // read and written in the same cycle
  always_comb begin
    mem_rd_en   = ((state == ST_SCAN) || (state == ST_WRITE)) && (ptr < end_q);
    mem_rd_addr = ptr[SEG_W-1:0];
    if (state == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = ptr[SEG_W-1:0];
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = (state == ST_WRITE) && rd_valid;
      mem_wr_addr = rd_addr_q;
      mem_wr_data = sat_load_add(mem_rd_data, grant);
    end
  end

  // Track read data returning in the cycle after each request
  always_ff @(posedge clk) begin
    rd_addr_q <= ptr[SEG_W-1:0];
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= mem_rd_en;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      ptr       <= '0;
      clr_reply <= 1'b0;
      total     <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr == LAST_C) begin
            state <= ST_IDLE;
            ptr   <= '0;
            if (clr_reply) begin
              result    <= '{granted: '0, running_total: '0, job_done: 1'b0};
              done      <= 1'b1;
              clr_reply <= 1'b0;
            end
          end
        end
        ST_IDLE: begin
          if (start) begin
            if (command) begin
              state     <= ST_CLEAR;
              ptr       <= '0;
              clr_reply <= 1'b1;
              total     <= '0;
            end else begin
              state   <= ST_SCAN;
              ptr     <= start_ext;
              start_q <= start_ext;
              end_q   <= end_clamp;
              req_q   <= requested;
              last_q  <= last_request;
              peak    <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (mem_rd_en) begin
            ptr <= ptr + 1'b1;
          end
          if (rd_valid && (mem_rd_data > peak)) begin
            peak <= mem_rd_data;
          end
          if (!mem_rd_en && !rd_valid) begin
            state <= ST_GRANT;
          end
        end
        ST_GRANT: begin
          grant <= grant_calc(peak, capacity, req_q);
          ptr   <= start_q;
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (mem_rd_en) begin
            ptr <= ptr + 1'b1;
          end
          if (!mem_rd_en && !rd_valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          total  <= total_next;
          result <= '{granted: grant, running_total: total_next, job_done: last_q};
          done   <= 1'b1;
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_CLEAR;
          ptr   <= '0;
        end
      endcase
    end
  end

endmodule
